@@ rtl/core/assert_macros.svh @@
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/tcgsp_pkg.sv @@
// Package of types and constants for the turn-constrained grid path search.
package tcgsp_pkg;
  localparam int unsigned CostW = 4;
  localparam int unsigned DistW = 20;
  localparam int unsigned CfgW  = 9;
  localparam logic [DistW-1:0] DistInf = '1;
  localparam logic CfgRowIdx = 1'b0;
  localparam logic CfgColIdx = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_CLEAR, ST_SCAN_RD, ST_SCAN_CHK, ST_PICK, ST_RELAX_RD, ST_RELAX_WR,
    ST_FIN_RD, ST_FIN_CHK, ST_OUT
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic clr_start;
    logic clr_step;
    logic scan_start;
    logic scan_rd;
    logic scan_chk;
    logic relax_start;
    logic relax_rd;
    logic relax_wr;
    logic fin_rd;
    logic fin_chk;
  } cmd_t;

  typedef struct packed {
    logic last_cell;
    logic single;
    logic clr_done;
    logic scan_done;
    logic found;
    logic relax_done;
    logic fin_done;
  } sts_t;
endpackage

@@ rtl/core/turn_constrained_grid_shortest_path.sv @@
// Top level of the turn-constrained grid shortest path block.
// Usage: write row_count (index 0) and column_count (index 1) through the cfg
// port while idle; each write restarts loading at cell 0. Stream the cell
// costs in row-major order, one beat per cycle on in_valid/in_ready. After
// the beat of the last cell the block stops taking beats and runs its
// search: a clearing sweep over all nodes, then rounds of a full scan of
// all nodes to pick the least unsettled one, then settling it and up to
// 2*MAX_RUN neighbour reads (six by default). There is one round per
// reachable node plus a last one; the full scans over the distance memory
// port dominate the search time. The two target nodes are then read and
// the lesser distance taken. The single result beat waits on out_valid
// until out_ready takes it, and loading resumes on the next cycle. A
// one-cell grid gives 0 on the cycle after its beat. Unreachable or very
// large totals read as all ones. Reset puts the block in the load state at
// cell 0 with both sizes at 1.
module turn_constrained_grid_shortest_path import tcgsp_pkg::*; #(
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_RUN     = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CfgW-1:0]  cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CostW-1:0] in_cell_cost,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DistW-1:0] out_min_total_cost
);
  `include "assert_macros.svh"

  logic [CfgW-1:0] row_r, col_r;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= CfgW'(1);
      col_r <= CfgW'(1);
    end else if (cfg_we) begin
      if (cfg_index == CfgRowIdx) row_r <= cfg_wdata;
      else col_r <= cfg_wdata;
    end
  end

  tcgsp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  tcgsp_datapath #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .MAX_RUN(MAX_RUN)
  ) u_dp (
    .clk, .rst_n, .cfg_we, .row_q(row_r), .col_q(col_r), .in_cell_cost,
    .cmd, .sts, .result(out_min_total_cost)
  );

  `ASSERT_IMP(a_no_in_and_out, clk, rst_n, out_valid, !in_ready)
  `ASSERT_NXT(a_out_take, clk, rst_n, out_valid && out_ready, in_ready)
  `ASSERT_NXT(a_single, clk, rst_n,
    in_valid && in_ready && sts.single && sts.last_cell, out_valid)
endmodule

@@ rtl/core/tcgsp_datapath.sv @@
// Datapath of the grid path search: cost, distance and settled memories and the relaxation unit.
module tcgsp_datapath import tcgsp_pkg::*; #(
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_RUN     = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CfgW-1:0]  row_q,
  input  logic [CfgW-1:0]  col_q,
  input  logic [CostW-1:0] in_cell_cost,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic [DistW-1:0] result
);
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned AW = RW + CW;
  localparam int unsigned NW = AW + 1;
  localparam int unsigned SW = $clog2(MAX_RUN + 1);
  localparam int unsigned CellCap = 1 << AW;

  // Effective sizes, minus one.
  logic [RW-1:0] rmax;
  logic [CW-1:0] cmax;
  always_comb begin
    if (row_q == '0) rmax = '0;
    else if (32'(row_q) > MAX_ROWS) rmax = RW'(MAX_ROWS - 1);
    else rmax = RW'(row_q - 9'd1);
    if (col_q == '0) cmax = '0;
    else if (32'(col_q) > MAX_COLUMNS) cmax = CW'(MAX_COLUMNS - 1);
    else cmax = CW'(col_q - 9'd1);
  end

  // Cells are addressed as {row, column}; nodes append the axis bit.
  logic [CostW-1:0] cost_mem [CellCap];
  logic [DistW-1:0] dist_mem [2*CellCap];
  logic             done_mem [2*CellCap];

  logic [RW-1:0] ld_r_r, ld_r_nxt;
  logic [CW-1:0] ld_c_r, ld_c_nxt;
  logic [NW-1:0] clr_r;
  logic          clr_done_r;
  logic [NW-1:0] scan_r;
  logic          scan_end_r;
  logic [DistW-1:0] best_r;
  logic [NW-1:0]    best_n_r;
  logic             found_r;
  logic [DistW-1:0] rd_dist_r;
  logic             rd_done_r;
  logic [CostW-1:0] rd_cost_r;
  logic [DistW-1:0] acc_r;
  logic [SW-1:0]    step_r;
  logic             sgn_r;
  logic [RW-1:0]    cr_r;
  logic [CW-1:0]    cc_r;
  logic             tgt_ok_r, relax_end_r, fin_half_r;
  logic [DistW-1:0] fin_a_r, result_r;

  // Load position.
  always_comb begin
    ld_r_nxt = ld_r_r;
    ld_c_nxt = ld_c_r;
    if (ld_c_r >= cmax) begin
      ld_c_nxt = '0;
      ld_r_nxt = (ld_r_r >= rmax) ? '0 : ld_r_r + RW'(1);
    end else begin
      ld_c_nxt = ld_c_r + CW'(1);
    end
  end
  assign sts.last_cell = (ld_r_r >= rmax) && (ld_c_r >= cmax);
  assign sts.single    = (rmax == '0) && (cmax == '0);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      ld_r_r <= '0;
      ld_c_r <= '0;
    end else if (cmd.load_wr) begin
      ld_r_r <= ld_r_nxt;
      ld_c_r <= ld_c_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.load_wr) cost_mem[{ld_r_r, ld_c_r}] <= in_cell_cost;
  end

  // Candidate target of the current relaxation step.
  logic [NW-1:0] src_n;
  logic          axis;
  logic [RW-1:0] tr;
  logic [CW-1:0] tc;
  logic          t_ok;
  assign src_n = best_n_r;
  assign axis  = src_n[0];
  always_comb begin
    tr = cr_r;
    tc = cc_r;
    t_ok = 1'b1;
    if (!axis) begin
      if (sgn_r) begin
        t_ok = (cr_r != '0);
        tr = cr_r - RW'(1);
      end else begin
        t_ok = (cr_r < rmax);
        tr = cr_r + RW'(1);
      end
    end else begin
      if (sgn_r) begin
        t_ok = (cc_r != '0);
        tc = cc_r - CW'(1);
      end else begin
        t_ok = (cc_r < cmax);
        tc = cc_r + CW'(1);
      end
    end
  end
  logic [NW-1:0] tgt_n;
  assign tgt_n = {tr, tc, ~axis};
  logic [DistW:0] sum;
  assign sum = {1'b0, acc_r} + {{(DistW+1-CostW){1'b0}}, rd_cost_r};
  logic [DistW-1:0] new_d;
  assign new_d = sum[DistW] ? DistInf : sum[DistW-1:0];

  logic [NW-1:0] rd_addr;
  always_comb begin
    rd_addr = scan_r;
    if (cmd.relax_rd) rd_addr = tgt_n;
    if (cmd.fin_rd) rd_addr = {rmax, cmax, fin_half_r};
  end

  logic clr_last;
  assign clr_last = (clr_r == {rmax, cmax, 1'b1});

  always_ff @(posedge clk) begin
    rd_dist_r <= dist_mem[rd_addr];
    rd_done_r <= done_mem[rd_addr];
    rd_cost_r <= cost_mem[rd_addr[NW-1:1]];
    if (cmd.clr_step) begin
      dist_mem[clr_r] <= (clr_r[NW-1:1] == '0) ? '0 : DistInf;
      done_mem[clr_r] <= 1'b0;
    end else if (cmd.relax_wr && tgt_ok_r && new_d < rd_dist_r) begin
      dist_mem[tgt_n] <= new_d;
    end else if (cmd.relax_start) begin
      done_mem[best_n_r] <= 1'b1;
    end
  end

  // Sweep and scan counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      clr_done_r <= 1'b0;
      scan_r <= '0;
      scan_end_r <= 1'b0;
      found_r <= 1'b0;
      fin_half_r <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        clr_r <= '0;
        clr_done_r <= 1'b0;
      end else if (cmd.clr_step) begin
        clr_done_r <= clr_last;
        if (clr_r[0] && clr_r[CW:1] >= cmax)
          clr_r <= {clr_r[NW-1:CW+1] + RW'(1), CW'(0), 1'b0};
        else
          clr_r <= clr_r + NW'(1);
      end
      if (cmd.scan_start) begin
        scan_r <= '0;
        scan_end_r <= 1'b0;
        found_r <= 1'b0;
        best_r <= DistInf;
      end else if (cmd.scan_rd) begin
        scan_end_r <= (scan_r == {rmax, cmax, 1'b1});
      end else if (cmd.scan_chk) begin
        if (!rd_done_r && rd_dist_r != DistInf && (!found_r || rd_dist_r < best_r)) begin
          best_r <= rd_dist_r;
          best_n_r <= scan_r;
          found_r <= 1'b1;
        end
        if (scan_r[0] && scan_r[CW:1] >= cmax)
          scan_r <= {scan_r[NW-1:CW+1] + RW'(1), CW'(0), 1'b0};
        else
          scan_r <= scan_r + NW'(1);
      end
      if (cmd.scan_start) fin_half_r <= 1'b0;
      else if (cmd.fin_chk) fin_half_r <= ~fin_half_r;
    end
  end
  assign sts.clr_done  = clr_done_r;
  assign sts.scan_done = scan_end_r;
  assign sts.found     = found_r;

  // Relaxation walker: up to MAX_RUN cells each way, each cell a read step then a write step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relax_end_r <= 1'b0;
      tgt_ok_r <= 1'b0;
    end else if (cmd.relax_start) begin
      cr_r <= best_n_r[NW-1:CW+1];
      cc_r <= best_n_r[CW:1];
      acc_r <= best_r;
      step_r <= SW'(1);
      sgn_r <= 1'b0;
      relax_end_r <= 1'b0;
    end else if (cmd.relax_rd) begin
      tgt_ok_r <= t_ok;
    end else if (cmd.relax_wr) begin
      if (tgt_ok_r && 32'(step_r) < MAX_RUN) begin
        cr_r <= tr;
        cc_r <= tc;
        acc_r <= new_d;
        step_r <= step_r + SW'(1);
        tgt_ok_r <= t_ok;
      end else if (!sgn_r) begin
        cr_r <= best_n_r[NW-1:CW+1];
        cc_r <= best_n_r[CW:1];
        acc_r <= best_r;
        step_r <= SW'(1);
        sgn_r <= 1'b1;
      end else begin
        relax_end_r <= 1'b1;
      end
    end
  end
  assign sts.relax_done = relax_end_r;

  // Final minimum over the two target nodes, or 0 for a one-cell grid.
  always_ff @(posedge clk) begin
    if (cmd.fin_chk) begin
      if (!fin_half_r) fin_a_r <= rd_dist_r;
      else result_r <= (rd_dist_r < fin_a_r) ? rd_dist_r : fin_a_r;
    end
    if (cmd.load_wr && sts.single && sts.last_cell) result_r <= '0;
  end
  assign sts.fin_done = fin_half_r;
  assign result = result_r;
endmodule

@@ rtl/core/tcgsp_ctrl.sv @@
// Controller state machine of the grid path search.
module tcgsp_ctrl import tcgsp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (sts.last_cell) begin
            if (sts.single) state_nxt = ST_OUT;
            else begin
              cmd.clr_start = 1'b1;
              state_nxt = ST_CLEAR;
            end
          end
        end
      end
      ST_CLEAR: begin
        if (sts.clr_done) begin
          cmd.scan_start = 1'b1;
          state_nxt = ST_SCAN_RD;
        end else cmd.clr_step = 1'b1;
      end
      ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        if (!sts.scan_done) state_nxt = ST_SCAN_RD;
        else state_nxt = ST_PICK;
      end
      ST_PICK: begin
        // The whole scan is done; either settle the best node or finish.
        if (!sts.found) state_nxt = ST_FIN_RD;
        else begin
          cmd.relax_start = 1'b1;
          state_nxt = ST_RELAX_RD;
        end
      end
      ST_RELAX_RD: begin
        if (sts.relax_done) begin
          cmd.scan_start = 1'b1;
          state_nxt = ST_SCAN_RD;
        end else begin
          cmd.relax_rd = 1'b1;
          state_nxt = ST_RELAX_WR;
        end
      end
      ST_RELAX_WR: begin
        cmd.relax_wr = 1'b1;
        state_nxt = ST_RELAX_RD;
      end
      ST_FIN_RD: begin
        cmd.fin_rd = 1'b1;
        state_nxt = ST_FIN_CHK;
      end
      ST_FIN_CHK: begin
        cmd.fin_chk = 1'b1;
        if (sts.fin_done) state_nxt = ST_OUT;
        else state_nxt = ST_FIN_RD;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule

@@ tb/sv/turn_constrained_grid_shortest_path_test.sv @@
// Self-checking testbench for the turn-constrained grid shortest path block.
`timescale 1ns / 1ps

module turn_constrained_grid_shortest_path_test import tcgsp_pkg::*; ();

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned IdleWait   = 10;

  typedef struct {
    bit             is_write;
    logic           reg_idx;
    bit [CfgW-1:0]  reg_val;
    bit [CostW-1:0] cost;
    bit             typed;
    bit [DistW-1:0] typed_cost;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CfgRowIdx;
  logic [CfgW-1:0]  cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CostW-1:0] in_cell_cost = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DistW-1:0] out_min_total_cost;

  // Predictor state.
  bit [CostW-1:0]   grid_cost [65536];
  int unsigned      load_pos;
  bit [CfgW-1:0]    rows_reg = 1;
  bit [CfgW-1:0]    cols_reg = 1;
  bit [DistW-1:0]   pending_costs [$];

  int unsigned      error_count;
  int unsigned      cycle_count;
  int unsigned      beats_sent;
  int unsigned      idle_mode;
  int unsigned      hold_left;
  bit               hold_req;
  bit               hold_done;

  turn_constrained_grid_shortest_path DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cell_cost       (in_cell_cost),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_min_total_cost (out_min_total_cost)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned used_size(bit [CfgW-1:0] v);
    if (v == 0) return 1;
    return (v > 256) ? 256 : v;
  endfunction

  // Dijkstra over (cell, axis of last move); axis 0 means the last move was horizontal.
  function automatic bit [DistW-1:0] shortest_cost(int rows, int cols);
    int unsigned dsum [];
    bit          settled [];
    int          n, best, cell_idx, r, c, rr, cc, s, k, node;
    int unsigned acc, a;
    n = 2 * rows * cols;
    dsum = new[n];
    settled = new[n];
    foreach (dsum[i]) dsum[i] = 32'hFFFF_FFFF;
    dsum[0] = 0;
    dsum[1] = 0;
    while (1) begin
      best = -1;
      for (int i = 0; i < n; i++)
        if (!settled[i] && dsum[i] != 32'hFFFF_FFFF && (best < 0 || dsum[i] < dsum[best]))
          best = i;
      if (best < 0) break;
      settled[best] = 1'b1;
      cell_idx = best >> 1;
      r = cell_idx / cols;
      c = cell_idx % cols;
      for (s = -1; s <= 1; s += 2) begin
        rr = r;
        cc = c;
        acc = dsum[best];
        for (k = 1; k <= 3; k++) begin
          if (best & 1) cc += s;
          else rr += s;
          if (rr < 0 || cc < 0 || rr >= rows || cc >= cols) break;
          acc += grid_cost[rr * cols + cc];
          node = (rr * cols + cc) * 2 + ((best & 1) ^ 1);
          if (acc < dsum[node]) dsum[node] = acc;
        end
      end
    end
    a = (dsum[n-2] < dsum[n-1]) ? dsum[n-2] : dsum[n-1];
    return (a >= 32'hFFFFF) ? DistInf : a[DistW-1:0];
  endfunction

  // Returns 1 when the beat completes a grid and queues the expected cost.
  function automatic bit load_cell(bit [CostW-1:0] cost, bit typed, bit [DistW-1:0] typed_cost);
    int unsigned rows, cols;
    rows = used_size(rows_reg);
    cols = used_size(cols_reg);
    if (load_pos >= rows * cols) load_pos = 0;
    grid_cost[load_pos] = cost;
    load_pos++;
    if (load_pos < rows * cols) return 0;
    load_pos = 0;
    pending_costs = {pending_costs,
                     typed ? typed_cost : shortest_cost(int'(rows), int'(cols))};
    return 1;
  endfunction

  task automatic report_mismatch(string what, bit [DistW-1:0] got, bit [DistW-1:0] want);
    error_count++;
    $display("mismatch: %s got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
  endtask

  // Register writes happen only with nothing outstanding; called at a rising edge.
  task automatic write_reg(logic idx, bit [CfgW-1:0] val);
    in_valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgRowIdx) rows_reg = val;
    else cols_reg = val;
    load_pos = 0;
  endtask

  task automatic send_cell(bit [CostW-1:0] cost, bit typed, bit [DistW-1:0] typed_cost);
    int unsigned gap_pct;
    gap_pct = (idle_mode == 0) ? 20 : (idle_mode == 1) ? 52 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_cost <= cost;
    do @(negedge clk); while (!in_ready);
    void'(load_cell(cost, typed, typed_cost));
    beats_sent++;
    @(posedge clk);
  endtask

  task automatic send_grid(bit [CfgW-1:0] rows, bit [CfgW-1:0] cols);
    int unsigned n;
    write_reg(CfgRowIdx, rows);
    write_reg(CfgColIdx, cols);
    n = used_size(rows) * used_size(cols);
    // Now and then the grid is abandoned part way to test the load restart.
    if (n > 2 && $urandom_range(19) == 0) n = $urandom_range(n - 1, 1);
    repeat (n)
      send_cell(CostW'(($urandom_range(99) < 85) ? $urandom_range(9) : $urandom_range(15)),
                1'b0, '0);
  endtask

  // Result side: random stalls plus a single long hold-off.
  always @(posedge clk) begin
    int unsigned stall_pct;
    stall_pct = (idle_mode == 0) ? 52 : (idle_mode == 1) ? 20 : 0;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // out_ready only changes at the rising edge, so a beat seen here is taken at the next one.
  always @(negedge clk) begin
    bit [DistW-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_costs.size() == 0) begin
        report_mismatch("unexpected beat", out_min_total_cost, '0);
      end else begin
        want = pending_costs.pop_front();
        if (out_min_total_cost !== want)
          report_mismatch("min_total_cost", out_min_total_cost, want);
      end
    end
  end

  stim_row_t directed [$] = '{
    '{0, CfgRowIdx, 0,   15, 1, 0},       // one-cell grid straight after reset
    '{0, CfgRowIdx, 0,   0,  1, 0},
    '{1, CfgColIdx, 5,   0,  0, 0},       // single row: the target cannot be reached
    '{0, CfgRowIdx, 0,   1,  0, 0},
    '{0, CfgRowIdx, 0,   2,  0, 0},
    '{0, CfgRowIdx, 0,   3,  0, 0},
    '{0, CfgRowIdx, 0,   4,  0, 0},
    '{0, CfgRowIdx, 0,   5,  1, DistInf},
    '{1, CfgRowIdx, 0,   0,  0, 0},       // zero size is taken as one
    '{1, CfgColIdx, 2,   0,  0, 0},
    '{0, CfgRowIdx, 0,   9,  0, 0},
    '{0, CfgRowIdx, 0,   7,  1, 7},
    '{1, CfgRowIdx, 511, 0,  0, 0},       // oversized, loaded only part way
    '{1, CfgColIdx, 256, 0,  0, 0},
    '{0, CfgRowIdx, 0,   12, 0, 0},
    '{0, CfgRowIdx, 0,   3,  0, 0},
    '{1, CfgRowIdx, 2,   0,  0, 0},
    '{1, CfgColIdx, 2,   0,  0, 0},
    '{0, CfgRowIdx, 0,   0,  0, 0},
    '{0, CfgRowIdx, 0,   9,  0, 0},
    '{0, CfgRowIdx, 0,   9,  0, 0},
    '{0, CfgRowIdx, 0,   15, 1, 24},
    '{1, CfgRowIdx, 3,   0,  0, 0},
    '{1, CfgColIdx, 1,   0,  0, 0},
    '{0, CfgRowIdx, 0,   10, 0, 0},
    '{0, CfgRowIdx, 0,   11, 0, 0},
    '{0, CfgRowIdx, 0,   14, 0, 0}
  };

  initial begin
    int unsigned wait_cycles;
    idle_mode = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_write) write_reg(directed[i].reg_idx, directed[i].reg_val);
      else send_cell(directed[i].cost, directed[i].typed, directed[i].typed_cost);
    end

    while (beats_sent < 900) begin
      idle_mode = (beats_sent < 330) ? 0 : (beats_sent < 630) ? 1 : 2;
      if (!hold_done && beats_sent > 120) begin
        // Long receiver hold-off over a run of one-cell grids fills the block up.
        hold_done = 1'b1;
        write_reg(CfgRowIdx, CfgW'(1));
        write_reg(CfgColIdx, CfgW'(1));
        hold_req = 1'b1;
        repeat (25) send_cell(CostW'($urandom_range(15)), 1'b0, '0);
      end else if ($urandom_range(24) == 0) begin
        if ($urandom_range(1)) send_grid(CfgW'(1), CfgW'($urandom_range(16, 6)));
        else send_grid(CfgW'($urandom_range(9, 6)), CfgW'($urandom_range(3, 1)));
      end else begin
        send_grid(CfgW'(($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1)),
                  CfgW'(($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1)));
      end
    end

    in_valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 50) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tcgsp_pkg.sv
rtl/core/tcgsp_datapath.sv
rtl/core/tcgsp_ctrl.sv
rtl/core/turn_constrained_grid_shortest_path.sv
tb/sv/turn_constrained_grid_shortest_path_test.sv
